/* src/assert_macros.svh */
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ESPD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ESPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/espd_pkg.sv */
// Shared types, widths and register codes of the encoder speed PID drive.
package espd_pkg;

  // Field and register widths.
  localparam int PPR_W       = 8;
  localparam int WIN_W       = 16;
  localparam int STEP_W      = 8;
  localparam int GAIN_W      = 12;
  localparam int SPEED_W     = 16;
  localparam int LEVEL_W     = 8;

  // Control loop arithmetic widths.
  localparam int ERR_W       = 18;
  localparam int DIF_W       = 19;
  localparam int INT_W       = 32;
  localparam int OPND_W      = 33;
  localparam int ACC_W       = 46;
  localparam int FRAC_BITS   = 8;
  localparam int ROUND_HALF  = 128;

  // Rpm scale factor, split into two shifts: 60 = 64 - 4.
  localparam int RPM_SHIFT_HI = 6;
  localparam int RPM_SHIFT_LO = 2;

  // Stream and APB widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  // Register reset values.
  localparam logic [PPR_W-1:0]  PPR_RST    = 8'd20;
  localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd488;
  localparam logic [STEP_W-1:0] STEP_RST   = 8'd25;
  localparam logic [GAIN_W-1:0] KP_RST     = 12'd256;
  localparam logic [GAIN_W-1:0] KI_RST     = 12'd26;
  localparam logic [GAIN_W-1:0] KD_RST     = 12'd13;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_PPR    = 3'd0,
    REG_WINDOW = 3'd1,
    REG_STEP   = 3'd2,
    REG_KP     = 3'd3,
    REG_KI     = 3'd4,
    REG_KD     = 3'd5
  } cfg_reg_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [PPR_W-1:0]  ppr;
    logic [WIN_W-1:0]  window;
    logic [STEP_W-1:0] step;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } espd_cfg_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MUL,
    ST_ROUND,
    ST_EMIT
  } espd_state_t;

  // Which PID term the multiply-accumulate unit works on.
  typedef enum logic [1:0] {
    PH_P,
    PH_I,
    PH_D
  } mac_phase_t;

endpackage

/* src/espd_cfg.sv */
// APB register file holding the window, scale, step and PID gain settings.
module espd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [espd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [espd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [espd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output espd_pkg::espd_cfg_t           regs
);
  import espd_pkg::*;

  espd_cfg_t regs_r;
  cfg_reg_t  reg_sel;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);
  assign regs       = regs_r;

  // Register writes in the access phase; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.ppr    <= PPR_RST;
      regs_r.window <= WINDOW_RST;
      regs_r.step   <= STEP_RST;
      regs_r.kp     <= KP_RST;
      regs_r.ki     <= KI_RST;
      regs_r.kd     <= KD_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PPR:    regs_r.ppr    <= cfg_pwdata[PPR_W-1:0];
        REG_WINDOW: regs_r.window <= cfg_pwdata[WIN_W-1:0];
        REG_STEP:   regs_r.step   <= cfg_pwdata[STEP_W-1:0];
        REG_KP:     regs_r.kp     <= cfg_pwdata[GAIN_W-1:0];
        REG_KI:     regs_r.ki     <= cfg_pwdata[GAIN_W-1:0];
        REG_KD:     regs_r.kd     <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_sel)
      REG_PPR:    cfg_prdata = CFG_DW'(regs_r.ppr);
      REG_WINDOW: cfg_prdata = CFG_DW'(regs_r.window);
      REG_STEP:   cfg_prdata = CFG_DW'(regs_r.step);
      REG_KP:     cfg_prdata = CFG_DW'(regs_r.kp);
      REG_KI:     cfg_prdata = CFG_DW'(regs_r.ki);
      REG_KD:     cfg_prdata = CFG_DW'(regs_r.kd);
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

/* src/espd_div.sv */
// Bit-serial restoring divider that turns a pulse count into rpm.
module espd_div #(
  parameter int CNT_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CNT_W-1:0]            pulses,
  input  logic [espd_pkg::PPR_W-1:0]  ppr,
  output logic                        done,
  output logic [CNT_W+5:0]            quot
);
  import espd_pkg::*;

  localparam int DVD_W   = CNT_W + 6;
  localparam int STEP_CW = $clog2(DVD_W);

  logic               busy_r;
  logic               done_r;
  logic [STEP_CW-1:0] cnt_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [PPR_W-1:0]   rem_r;
  logic [PPR_W-1:0]   dvs_r;

  logic [DVD_W-1:0]   prod60;
  logic [PPR_W+1:0]   trial;
  logic               qbit;

  // Pulses times 60 as a shift pair, then one trial subtract per cycle.
  assign prod60 = (DVD_W'(pulses) << RPM_SHIFT_HI) - (DVD_W'(pulses) << RPM_SHIFT_LO);
  assign trial  = {1'b0, rem_r, dvd_r[DVD_W-1]} - {2'b00, dvs_r};
  assign qbit   = !trial[PPR_W+1];

  assign done = done_r;
  assign quot = dvd_r;

  // Step counter and handshake flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_CW'(1);
        if (cnt_r == STEP_CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= prod60;
      rem_r <= '0;
      dvs_r <= (ppr == '0) ? PPR_W'(1) : ppr;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      if (qbit) begin
        rem_r <= trial[PPR_W-1:0];
      end else begin
        rem_r <= {rem_r[PPR_W-2:0], dvd_r[DVD_W-1]};
      end
    end
  end

endmodule

/* src/espd_mac.sv */
// Bit-serial multiply-accumulate unit for the three PID terms.
module espd_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                clear,
  input  logic [espd_pkg::GAIN_W-1:0]         gain,
  input  logic signed [espd_pkg::OPND_W-1:0]  operand,
  output logic                                done,
  output logic signed [espd_pkg::ACC_W-1:0]   acc
);
  import espd_pkg::*;

  localparam int BIT_CW = $clog2(GAIN_W);

  logic                     busy_r;
  logic                     done_r;
  logic [BIT_CW-1:0]        cnt_r;
  logic [GAIN_W-1:0]        gain_r;
  logic signed [ACC_W-1:0]  op_r;
  logic signed [ACC_W-1:0]  acc_r;

  assign done = done_r;
  assign acc  = acc_r;

  // Gain bit counter and handshake flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + BIT_CW'(1);
        if (cnt_r == BIT_CW'(GAIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Gain shifts right one bit a cycle; the operand doubles and is added on a one.
  always_ff @(posedge clk) begin
    if (start) begin
      gain_r <= gain;
      op_r   <= {{(ACC_W-OPND_W){operand[OPND_W-1]}}, operand};
      if (clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      gain_r <= gain_r >> 1;
      op_r   <= op_r <<< 1;
      if (gain_r[0]) begin
        acc_r <= acc_r + op_r;
      end
    end
  end

endmodule

/* src/encoder_speed_pid_drive.sv */
// Top level of the encoder speed measurement and PID drive block.
// A request that closes no window goes straight to the output register if the output is free.
// A window close runs COUNT_BITS+6 divider steps and then three 12-bit serial products.
// Throughput: one request per cycle while no window closes and the output is free;
// a close holds off input until its result.
// Reset is synchronous, active low: it restores register defaults and zeros all loop state.
`include "assert_macros.svh"

module encoder_speed_pid_drive #(
  parameter int DRIVE_MAX  = 255,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: encoder_level, tick, up_press, down_press (bit 0 up)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [espd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: drive_level[7:0], forward, reverse, speed_rpm[15:0], speed_new
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [espd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [espd_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [espd_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [espd_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import espd_pkg::*;

  localparam int DRV_W     = $clog2(DRIVE_MAX + 1) + 1;
  localparam int TGT_SUM_W = ((DRV_W > STEP_W + 1) ? DRV_W : STEP_W + 1) + 1;
  localparam int DVD_W     = COUNT_BITS + 6;
  localparam int RND_W     = ACC_W + 1 - FRAC_BITS;

  localparam logic signed [DRV_W-1:0]     DRV_LIM = DRV_W'(DRIVE_MAX);
  localparam logic signed [TGT_SUM_W-1:0] TGT_LIM = TGT_SUM_W'(DRIVE_MAX);
  localparam logic signed [RND_W-1:0]     RND_LIM = RND_W'(DRIVE_MAX);

  espd_cfg_t cfg;

  // Architectural state.
  espd_state_t               state_r, state_nxt;
  logic                      last_level_r, last_level_nxt;
  logic [COUNT_BITS-1:0]     pulse_r, pulse_nxt;
  logic [WIN_W-1:0]          tick_r, tick_nxt;
  logic signed [DRV_W-1:0]   target_r, target_nxt;
  logic signed [INT_W-1:0]   integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, prev_err_nxt;
  logic signed [DRV_W-1:0]   drive_r, drive_nxt;
  logic [SPEED_W-1:0]        speed_r, speed_nxt;

  // Sequencing and result registers.
  mac_phase_t                phase_r, phase_nxt;
  logic                      mac_go_r, mac_go_nxt;
  logic                      closed_r, closed_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [DIF_W-1:0]   dif_r, dif_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;

  // Request fields and combinational helpers.
  logic                      in_level, in_tick, in_up, in_down;
  logic                      accept, out_free, win_close;
  logic [COUNT_BITS-1:0]     pulse_inc;
  logic [WIN_W-1:0]          tick_inc, win_eff;
  logic signed [TGT_SUM_W-1:0] tgt_ext, step_ext, tgt_sel;
  logic signed [DRV_W-1:0]   tgt_new;
  logic signed [ERR_W-1:0]   err_calc;
  logic signed [INT_W:0]     isum;
  logic signed [INT_W-1:0]   isat;
  logic signed [DIF_W-1:0]   dif_calc;
  logic signed [ACC_W:0]     rsum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [DRV_W-1:0]   drv_clamp;
  logic [DRV_W-1:0]          drive_mag;
  logic [LEVEL_W-1:0]        level;
  logic                      fwd, rev;
  logic [SPEED_W-1:0]        speed_sat;

  // Unit connections.
  logic                      div_done;
  logic [DVD_W-1:0]          div_quot;
  logic                      mac_done;
  logic [GAIN_W-1:0]         mac_gain;
  logic signed [OPND_W-1:0]  mac_opnd;
  logic signed [ACC_W-1:0]   mac_acc;

  espd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (cfg)
  );

  espd_div #(
    .CNT_W (COUNT_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && win_close),
    .pulses (pulse_inc),
    .ppr    (cfg.ppr),
    .done   (div_done),
    .quot   (div_quot)
  );

  espd_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_go_r),
    .clear   (phase_r == PH_P),
    .gain    (mac_gain),
    .operand (mac_opnd),
    .done    (mac_done),
    .acc     (mac_acc)
  );

  // Handshake.
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_level = in_tdata[0];
  assign in_tick  = in_tdata[1];
  assign in_up    = in_tdata[2];
  assign in_down  = in_tdata[3];

  // Edge and tick counting with the window check on the updated counts.
  assign pulse_inc = (in_level && !last_level_r && !(&pulse_r)) ?
                     pulse_r + COUNT_BITS'(1) : pulse_r;
  assign tick_inc  = tick_r + WIN_W'(in_tick);
  assign win_eff   = (cfg.window == '0) ? WIN_W'(1) : cfg.window;
  assign win_close = (tick_inc >= win_eff);

  // Target moved by one step per button event and held within the drive limits.
  assign tgt_ext  = {{(TGT_SUM_W-DRV_W){target_r[DRV_W-1]}}, target_r};
  assign step_ext = TGT_SUM_W'(cfg.step);
  always_comb begin
    if (in_up && !in_down) begin
      tgt_sel = tgt_ext + step_ext;
    end else if (in_down && !in_up) begin
      tgt_sel = tgt_ext - step_ext;
    end else begin
      tgt_sel = tgt_ext;
    end
    if (tgt_sel > TGT_LIM) begin
      tgt_new = DRV_LIM;
    end else if (tgt_sel < -TGT_LIM) begin
      tgt_new = -DRV_LIM;
    end else begin
      tgt_new = tgt_sel[DRV_W-1:0];
    end
  end

  // Rpm held at full scale when the quotient overflows 16 bits.
  assign speed_sat = (|(div_quot >> SPEED_W)) ? '1 : SPEED_W'(div_quot);

  // Error, saturating integral and difference for the PID step.
  assign err_calc = {{(ERR_W-DRV_W){target_r[DRV_W-1]}}, target_r} - ERR_W'(speed_r);
  assign isum     = {integ_r[INT_W-1], integ_r}
                  + {{(INT_W+1-ERR_W){err_calc[ERR_W-1]}}, err_calc};
  always_comb begin
    if (isum[INT_W] != isum[INT_W-1]) begin
      isat = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      isat = isum[INT_W-1:0];
    end
  end
  assign dif_calc = {err_calc[ERR_W-1], err_calc} - {prev_err_r[ERR_W-1], prev_err_r};

  // Gain and operand for the term in work.
  always_comb begin
    case (phase_r)
      PH_P: begin
        mac_gain = cfg.kp;
        mac_opnd = {{(OPND_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      PH_I: begin
        mac_gain = cfg.ki;
        mac_opnd = {{(OPND_W-INT_W){integ_r[INT_W-1]}}, integ_r};
      end
      PH_D: begin
        mac_gain = cfg.kd;
        mac_opnd = {{(OPND_W-DIF_W){dif_r[DIF_W-1]}}, dif_r};
      end
      default: begin
        mac_gain = '0;
        mac_opnd = '0;
      end
    endcase
  end

  // Round to nearest (ties up) by adding half and flooring, then clamp.
  assign rsum = {mac_acc[ACC_W-1], mac_acc} + (ACC_W+1)'(ROUND_HALF);
  assign rnd  = rsum[ACC_W:FRAC_BITS];
  always_comb begin
    if (rnd > RND_LIM) begin
      drv_clamp = DRV_LIM;
    end else if (rnd < -RND_LIM) begin
      drv_clamp = -DRV_LIM;
    end else begin
      drv_clamp = rnd[DRV_W-1:0];
    end
  end

  // Result fields from the held drive.
  assign drive_mag = drive_r[DRV_W-1] ? DRV_W'(-drive_r) : DRV_W'(drive_r);
  assign level     = LEVEL_W'(drive_mag);
  assign fwd       = !drive_r[DRV_W-1] && (|drive_r);
  assign rev       = drive_r[DRV_W-1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (win_close) begin
            state_nxt = ST_DIV;
          end else if (!out_free) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mac_done && phase_r == PH_D) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output register updates per state.
  always_comb begin
    last_level_nxt = last_level_r;
    pulse_nxt      = pulse_r;
    tick_nxt       = tick_r;
    target_nxt     = target_r;
    integ_nxt      = integ_r;
    prev_err_nxt   = prev_err_r;
    drive_nxt      = drive_r;
    speed_nxt      = speed_r;
    phase_nxt      = phase_r;
    mac_go_nxt     = 1'b0;
    closed_nxt     = closed_r;
    err_nxt        = err_r;
    dif_nxt        = dif_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_level_nxt = in_level;
          target_nxt     = tgt_new;
          if (win_close) begin
            pulse_nxt  = '0;
            tick_nxt   = '0;
            closed_nxt = 1'b1;
          end else begin
            pulse_nxt  = pulse_inc;
            tick_nxt   = tick_inc;
            closed_nxt = 1'b0;
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = OUT_TDATA_W'({1'b0, speed_r, rev, fwd, level});
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          speed_nxt = speed_sat;
        end
      end
      ST_ERR: begin
        err_nxt      = err_calc;
        dif_nxt      = dif_calc;
        integ_nxt    = isat;
        prev_err_nxt = err_calc;
        phase_nxt    = PH_P;
        mac_go_nxt   = 1'b1;
      end
      ST_MUL: begin
        if (mac_done) begin
          case (phase_r)
            PH_P: begin
              phase_nxt  = PH_I;
              mac_go_nxt = 1'b1;
            end
            PH_I: begin
              phase_nxt  = PH_D;
              mac_go_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ROUND: begin
        drive_nxt = drv_clamp;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({closed_r, speed_r, rev, fwd, level});
        end
      end
      default: ;
    endcase
  end

  // Control and loop state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_level_r <= 1'b0;
      pulse_r      <= '0;
      tick_r       <= '0;
      target_r     <= '0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      drive_r      <= '0;
      speed_r      <= '0;
      phase_r      <= PH_P;
      mac_go_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_level_r <= last_level_nxt;
      pulse_r      <= pulse_nxt;
      tick_r       <= tick_nxt;
      target_r     <= target_nxt;
      integ_r      <= integ_nxt;
      prev_err_r   <= prev_err_nxt;
      drive_r      <= drive_nxt;
      speed_r      <= speed_nxt;
      phase_r      <= phase_nxt;
      mac_go_r     <= mac_go_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    closed_r   <= closed_nxt;
    err_r      <= err_nxt;
    dif_r      <= dif_nxt;
    out_data_r <= out_data_nxt;
  end

  // A window close always moves the sequencer to the divide state in the next cycle.
  `ESPD_ASSERT_NEXT(a_close_div, clk, rst_n, accept && win_close, state_r == ST_DIV, "no divide")
  // The divider only finishes while the sequencer waits for it.
  `ESPD_ASSERT_IMPLIES(a_div_done, clk, rst_n, div_done, state_r == ST_DIV, "stray divider done")
  // The multiplier only finishes while the sequencer waits for it.
  `ESPD_ASSERT_IMPLIES(a_mac_done, clk, rst_n, mac_done, state_r == ST_MUL, "stray product done")
  // The held drive never leaves its saturation range.
  `ESPD_ASSERT_IMPLIES(a_drv_hi, clk, rst_n, 1'b1, drive_r <= DRV_LIM, "drive above limit")
  `ESPD_ASSERT_IMPLIES(a_drv_lo, clk, rst_n, 1'b1, drive_r >= -DRV_LIM, "drive below limit")

endmodule
